### design/jiq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jiq_pkg
// Shared constants and types for the joystick input qualifier.
// ----------------------------------------------------------------------------
package jiq_pkg;

    localparam int NUM_AXES    = 4;
    localparam int NUM_BUTTONS = 16;
    localparam int NUM_HATS    = 4;

    localparam int NUM_SLOTS = NUM_AXES + NUM_BUTTONS + NUM_HATS;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int AXIS_IW   = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;
    localparam int BTN_IW    = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
    localparam int HAT_IW    = (NUM_HATS > 1) ? $clog2(NUM_HATS) : 1;

    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] OP_AXIS   = 2'd0;
    localparam logic [1:0] OP_BUTTON = 2'd1;
    localparam logic [1:0] OP_HAT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_DEADZONES     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITIES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINIMUMS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXIMUMS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_EN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = 3'd5;

    localparam logic [15:0] REPEAT_DELAY_RST = 16'd500;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_CENTER,
        S_LOAD,
        S_DIV,
        S_SAT,
        S_DECIDE
    } state_t;

endpackage

### design/joystick_input_qualifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_input_qualifier
// Qualifies axis, button and hat samples: axis calibration and scaling,
// deadzone, sensitivity threshold and auto-repeat.
// ----------------------------------------------------------------------------
//  channel | ports                                       | handshake
//  --------+---------------------------------------------+--------------
//  sample  | s_opcode s_channel s_sample_value s_time_now | s_valid/s_ready
//  event   | m_event_kind m_event_channel m_event_value   | m_valid/m_ready
//  config  | cfg_wr_en cfg_index cfg_wr_data              | write only
//
//  Axis beat: the next accept waits until the radix-2 restoring divider
//  is through (16 iterations, one quotient bit per cycle); a quotient that
//  saturates skips the divider, and max <= min skips centring and divider.
//  Button and hat beats skip both; a bad channel or opcode is dropped after prep.
//  Reset is synchronous; state tables clear at once, no sweep.
//  A result waits in the output register; the next beat is accepted meanwhile
//  and only its final decide cycle stalls while that register is full.
// ----------------------------------------------------------------------------
module joystick_input_qualifier
    import jiq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_opcode,
    input  logic [3:0]           s_channel,
    input  logic signed [15:0]   s_sample_value,
    input  logic [15:0]          s_time_now,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [1:0]           m_event_kind,
    output logic [3:0]           m_event_channel,
    output logic signed [15:0]   m_event_value,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    state_t state_reg, state_next;

    logic [CFG_W-1:0] dz_reg,   dz_next;
    logic [CFG_W-1:0] sens_reg, sens_next;
    logic [CFG_W-1:0] min_reg,  min_next;
    logic [CFG_W-1:0] max_reg,  max_next;
    logic             rep_en_reg, rep_en_next;
    logic [15:0]      rep_delay_reg, rep_delay_next;

    logic [15:0] last_axis_reg   [NUM_AXES];
    logic [15:0] last_axis_next  [NUM_AXES];
    logic        last_btn_reg    [NUM_BUTTONS];
    logic        last_btn_next   [NUM_BUTTONS];
    logic [3:0]  last_hat_reg    [NUM_HATS];
    logic [3:0]  last_hat_next   [NUM_HATS];
    logic [15:0] stamp_reg       [NUM_SLOTS];
    logic [15:0] stamp_next      [NUM_SLOTS];

    logic [1:0]        op_reg,    op_next;
    logic [3:0]        ch_reg,    ch_next;
    logic [15:0]       raw_reg,   raw_next;
    logic [15:0]       now_reg,   now_next;
    logic [SLOT_W-1:0] slot_reg,  slot_next;
    logic [15:0]       mid_reg,   mid_next;
    logic [15:0]       den_reg,   den_next;
    logic [15:0]       cmag_reg,  cmag_next;
    logic              neg_reg,   neg_next;
    logic              over_reg,  over_next;
    logic [15:0]       rem_reg,   rem_next;
    logic [15:0]       quo_reg,   quo_next;
    logic [3:0]        cnt_reg,   cnt_next;
    logic [15:0]       value_reg, value_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  m_kind_reg,  m_kind_next;
    logic [3:0]  m_chan_reg,  m_chan_next;
    logic [15:0] m_value_reg, m_value_next;

    // lane select and calibration
    logic [5:0]  lane;
    logic [15:0] mx, mn, dz, sens;
    logic [16:0] sum17, sum_adj, diff17, c17, c_abs;
    logic        axis_ok;
    logic [31:0] prod;
    logic        prod_over;

    // divider step
    logic [16:0] trial, trial_sub;
    logic        trial_ge;
    logic [15:0] sat_value;

    // decision
    logic [16:0] v17, mag17, d17, delta17;
    logic [15:0] prev_axis, stamp_rd, elapsed;
    logic        held, changed, nonzero, in_dz;
    logic        ch_ok;
    logic        out_free, fire;
    logic        report, stamp_wr, store_wr;

    assign lane  = {ch_reg[1:0], 4'b0000};
    assign mx    = max_reg[lane +: 16];
    assign mn    = min_reg[lane +: 16];
    assign dz    = dz_reg[lane +: 16];
    assign sens  = sens_reg[lane +: 16];

    assign sum17   = {mx[15], mx} + {mn[15], mn};
    assign sum_adj = sum17 + {16'd0, sum17[16]};
    assign diff17  = {mx[15], mx} - {mn[15], mn};
    assign axis_ok = !diff17[16] && (diff17 != 17'd0);

    assign c17   = {raw_reg[15], raw_reg} - {mid_reg[15], mid_reg};
    assign c_abs = c17[16] ? (17'd0 - c17) : c17;

    assign prod      = {cmag_reg, 16'h0000} - {16'h0000, cmag_reg};
    assign prod_over = prod[31:16] >= den_reg;

    assign trial     = {rem_reg, quo_reg[15]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    always_comb begin
        if (neg_reg) begin
            sat_value = (over_reg || (quo_reg > 16'd32768)) ? 16'h8000 : (16'd0 - quo_reg);
        end else begin
            sat_value = (over_reg || quo_reg[15]) ? 16'h7fff : quo_reg;
        end
    end

    assign v17       = {value_reg[15], value_reg};
    assign mag17     = v17[16] ? (17'd0 - v17) : v17;
    assign prev_axis = last_axis_reg[ch_reg[AXIS_IW-1:0]];
    assign d17       = {prev_axis[15], prev_axis} - v17;
    assign delta17   = d17[16] ? (17'd0 - d17) : d17;
    assign stamp_rd  = stamp_reg[slot_reg];
    assign elapsed   = now_reg - stamp_rd;
    assign held      = elapsed >= rep_delay_reg;
    assign nonzero   = value_reg != 16'd0;
    assign in_dz     = (op_reg == OP_AXIS) && (mag17 < {1'b0, dz});

    always_comb begin
        case (op_reg)
            OP_AXIS:   changed = prev_axis != value_reg;
            OP_BUTTON: changed = last_btn_reg[ch_reg[BTN_IW-1:0]] != value_reg[0];
            OP_HAT:    changed = last_hat_reg[ch_reg[HAT_IW-1:0]] != value_reg[3:0];
            default:   changed = 1'b0;
        endcase
    end

    always_comb begin
        case (op_reg)
            OP_AXIS:   ch_ok = 32'(ch_reg) < NUM_AXES;
            OP_BUTTON: ch_ok = 32'(ch_reg) < NUM_BUTTONS;
            OP_HAT:    ch_ok = 32'(ch_reg) < NUM_HATS;
            default:   ch_ok = 1'b0;
        endcase
    end

    always_comb begin
        report   = 1'b0;
        stamp_wr = 1'b0;
        store_wr = 1'b0;
        if (in_dz) begin
            report = 1'b1;
        end else if (changed) begin
            store_wr = 1'b1;
            stamp_wr = 1'b1;
            report   = (op_reg != OP_AXIS) || (delta17 >= {1'b0, sens});
        end else if (rep_en_reg && nonzero) begin
            report = held;
        end else begin
            stamp_wr = 1'b1;
        end
    end

    assign out_free = !m_valid_reg || m_ready;
    assign fire     = (state_reg == S_DECIDE) && out_free;
    assign s_ready  = state_reg == S_IDLE;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                if (!ch_ok) begin
                    state_next = S_IDLE;
                end else if ((op_reg == OP_AXIS) && axis_ok) begin
                    state_next = S_CENTER;
                end else begin
                    state_next = S_DECIDE;
                end
            end
            S_CENTER: state_next = S_LOAD;
            S_LOAD: begin
                state_next = prod_over ? S_SAT : S_DIV;
            end
            S_DIV: begin
                if (cnt_reg == 4'd15) begin
                    state_next = S_SAT;
                end
            end
            S_SAT: state_next = S_DECIDE;
            S_DECIDE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        dz_next        = dz_reg;
        sens_next      = sens_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        rep_en_next    = rep_en_reg;
        rep_delay_next = rep_delay_reg;
        last_axis_next = last_axis_reg;
        last_btn_next  = last_btn_reg;
        last_hat_next  = last_hat_reg;
        stamp_next     = stamp_reg;
        op_next        = op_reg;
        ch_next        = ch_reg;
        raw_next       = raw_reg;
        now_next       = now_reg;
        slot_next      = slot_reg;
        mid_next       = mid_reg;
        den_next       = den_reg;
        cmag_next      = cmag_reg;
        neg_next       = neg_reg;
        over_next      = over_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        value_next     = value_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_kind_next    = m_kind_reg;
        m_chan_next    = m_chan_reg;
        m_value_next   = m_value_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_DEADZONES:     dz_next        = cfg_wr_data;
                CFG_SENSITIVITIES: sens_next      = cfg_wr_data;
                CFG_MINIMUMS:      min_next       = cfg_wr_data;
                CFG_MAXIMUMS:      max_next       = cfg_wr_data;
                CFG_REPEAT_EN:     rep_en_next    = cfg_wr_data[0];
                CFG_REPEAT_DELAY:  rep_delay_next = cfg_wr_data[15:0];
                default: ;
            endcase
        end

        if (s_valid && s_ready) begin
            op_next  = s_opcode;
            ch_next  = s_channel;
            raw_next = s_sample_value;
            now_next = s_time_now;
        end

        case (state_reg)
            S_PREP: begin
                mid_next = sum_adj[16:1];
                den_next = diff17[15:0];
                case (op_reg)
                    OP_AXIS: begin
                        slot_next  = SLOT_W'(ch_reg);
                        value_next = 16'd0;
                    end
                    OP_BUTTON: begin
                        slot_next  = SLOT_W'(NUM_AXES) + SLOT_W'(ch_reg);
                        value_next = {15'd0, raw_reg != 16'd0};
                    end
                    default: begin
                        slot_next  = SLOT_W'(NUM_AXES + NUM_BUTTONS) + SLOT_W'(ch_reg);
                        value_next = {12'd0, raw_reg[3:0]};
                    end
                endcase
            end
            S_CENTER: begin
                cmag_next = c_abs[15:0];
                neg_next  = c17[16];
            end
            S_LOAD: begin
                over_next = prod_over;
                rem_next  = prod[31:16];
                quo_next  = prod[15:0];
                cnt_next  = 4'd0;
            end
            S_DIV: begin
                rem_next = trial_ge ? trial_sub[15:0] : trial[15:0];
                quo_next = {quo_reg[14:0], trial_ge};
                cnt_next = cnt_reg + 4'd1;
            end
            S_SAT: begin
                value_next = sat_value;
            end
            default: ;
        endcase

        if (fire) begin
            if (store_wr) begin
                case (op_reg)
                    OP_AXIS:   last_axis_next[ch_reg[AXIS_IW-1:0]] = value_reg;
                    OP_BUTTON: last_btn_next[ch_reg[BTN_IW-1:0]]   = value_reg[0];
                    default:   last_hat_next[ch_reg[HAT_IW-1:0]]   = value_reg[3:0];
                endcase
            end
            if (stamp_wr) begin
                stamp_next[slot_reg] = now_reg;
            end
            if (report) begin
                m_valid_next = 1'b1;
                m_kind_next  = op_reg;
                m_chan_next  = ch_reg;
                m_value_next = in_dz ? 16'd0 : value_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            dz_reg        <= '0;
            sens_reg      <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            rep_en_reg    <= 1'b0;
            rep_delay_reg <= REPEAT_DELAY_RST;
            cnt_reg       <= '0;
            m_valid_reg   <= 1'b0;
            for (int i = 0; i < NUM_AXES; i++) begin
                last_axis_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                last_btn_reg[i] <= 1'b0;
            end
            for (int i = 0; i < NUM_HATS; i++) begin
                last_hat_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_SLOTS; i++) begin
                stamp_reg[i] <= '0;
            end
        end else begin
            state_reg     <= state_next;
            dz_reg        <= dz_next;
            sens_reg      <= sens_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            rep_en_reg    <= rep_en_next;
            rep_delay_reg <= rep_delay_next;
            cnt_reg       <= cnt_next;
            m_valid_reg   <= m_valid_next;
            last_axis_reg <= last_axis_next;
            last_btn_reg  <= last_btn_next;
            last_hat_reg  <= last_hat_next;
            stamp_reg     <= stamp_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg      <= op_next;
        ch_reg      <= ch_next;
        raw_reg     <= raw_next;
        now_reg     <= now_next;
        slot_reg    <= slot_next;
        mid_reg     <= mid_next;
        den_reg     <= den_next;
        cmag_reg    <= cmag_next;
        neg_reg     <= neg_next;
        over_reg    <= over_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        value_reg   <= value_next;
        m_kind_reg  <= m_kind_next;
        m_chan_reg  <= m_chan_next;
        m_value_reg <= m_value_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_event_kind    = m_kind_reg;
    assign m_event_channel = m_chan_reg;
    assign m_event_value   = m_value_reg;

    // accepted beat always starts the prep step
    a_accept_prep: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == S_PREP))
        else $error("accepted beat did not enter prep");

    // divider partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_DECIDE))
        else $error("result raised outside decide");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> ((m_kind_reg == OP_AXIS)
                      || ((m_kind_reg == OP_BUTTON) && (m_value_reg[15:1] == 15'd0))
                      || ((m_kind_reg == OP_HAT) && (m_value_reg[15:4] == 12'd0))))
        else $error("bad button or hat event");

endmodule

### tb/joystick_input_qualifier_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_input_qualifier_test
// Self-checking bench for the joystick input qualifier. A queue of axis,
// button and hat samples feeds a valid/ready driver with random gaps; a
// monitor under random back-pressure checks each event against a local
// model of calibration, deadzone, sensitivity and auto-repeat. Several
// register settings are exercised, including the extremes.
// ----------------------------------------------------------------------------
module joystick_input_qualifier_test;
    import jiq_pkg::*;

    localparam int         CLK_PERIOD   = 10;
    localparam int         DRAIN_CYCLES = 40;
    localparam int         LONG_HOLD    = 400;
    localparam int         LIMIT_NS     = 12_000_000;
    localparam logic [1:0] OP_NONE      = 2'd3;

    typedef struct packed {
        logic [1:0]         op;
        logic [3:0]         ch;
        logic signed [15:0] raw;
        logic [15:0]        now;
    } sample_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         ch;
        logic signed [15:0] value;
    } qual_event_t;

    logic                 aclk           = 1'b0;
    logic                 aresetn        = 1'b0;
    logic                 s_valid        = 1'b0;
    logic                 s_ready;
    logic [1:0]           s_opcode       = '0;
    logic [3:0]           s_channel      = '0;
    logic signed [15:0]   s_sample_value = '0;
    logic [15:0]          s_time_now     = '0;
    logic                 m_valid;
    logic                 m_ready        = 1'b0;
    logic [1:0]           m_event_kind;
    logic [3:0]           m_event_channel;
    logic signed [15:0]   m_event_value;
    logic                 cfg_wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index      = '0;
    logic [CFG_W-1:0]     cfg_wr_data    = '0;

    joystick_input_qualifier u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_opcode        (s_opcode),
        .s_channel       (s_channel),
        .s_sample_value  (s_sample_value),
        .s_time_now      (s_time_now),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_event_kind    (m_event_kind),
        .m_event_channel (m_event_channel),
        .m_event_value   (m_event_value),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wr_data     (cfg_wr_data)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // register shadows
    logic [63:0] dz_reg    = '0;
    logic [63:0] sens_reg  = '0;
    logic [63:0] min_reg   = '0;
    logic [63:0] max_reg   = '0;
    logic        rep_en    = 1'b0;
    logic [15:0] rep_delay = REPEAT_DELAY_RST;

    // control state
    int          last_axis   [NUM_AXES];
    logic [3:0]  held_level  [NUM_BUTTONS + NUM_HATS];
    logic [15:0] hold_stamp  [NUM_SLOTS];

    sample_t     sample_queue[$];
    qual_event_t expected_events[$];

    bit          sample_taken = 1'b0;
    bit          quiet        = 1'b1;
    bit          hold_req     = 1'b0;
    int          gap_left     = 0;
    int          hold_left    = 0;
    int          stall_left   = 0;

    int          samples_taken   = 0;
    int          samples_ignored = 0;
    int          events_seen     = 0;
    int          settings_done   = 0;
    int          mismatches      = 0;

    logic [15:0]        tick = '0;
    logic signed [15:0] prev_axis_raw [NUM_AXES];
    logic signed [15:0] prev_btn_raw  [NUM_BUTTONS];
    logic signed [15:0] prev_hat_raw  [NUM_HATS];

    initial begin
        for (int i = 0; i < NUM_AXES; i++) begin
            last_axis[i]     = 0;
            prev_axis_raw[i] = '0;
        end
        for (int i = 0; i < NUM_BUTTONS + NUM_HATS; i++) held_level[i] = '0;
        for (int i = 0; i < NUM_SLOTS; i++) hold_stamp[i] = '0;
        for (int i = 0; i < NUM_BUTTONS; i++) prev_btn_raw[i] = '0;
        for (int i = 0; i < NUM_HATS; i++) prev_hat_raw[i] = '0;
    end

    // ---------------------------------------------------------------- model

    function automatic int scale_axis(input logic signed [15:0] raw, input int ch);
        longint hi, lo, c, q;
        hi = $signed(max_reg[ch*16 +: 16]);
        lo = $signed(min_reg[ch*16 +: 16]);
        if (hi <= lo) return 0;
        c = longint'(raw) - (hi + lo) / 2;
        q = (65535 * c) / (hi - lo);
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return int'(q);
    endfunction

    function automatic bit held_long(input int slot, input logic [15:0] now);
        logic [15:0] elapsed;
        elapsed = now - hold_stamp[slot];
        return elapsed >= rep_delay;
    endfunction

    // shared change / repeat decision for buttons and hats
    function automatic bit level_report(input int slot, input logic [3:0] level,
                                        input logic [15:0] now);
        if (level != held_level[slot - NUM_AXES]) begin
            held_level[slot - NUM_AXES] = level;
            hold_stamp[slot] = now;
            return 1'b1;
        end
        if (rep_en && level != 0) return held_long(slot, now);
        hold_stamp[slot] = now;
        return 1'b0;
    endfunction

    function automatic void qualify_sample(input logic [1:0] op, input logic [3:0] ch,
                                           input logic signed [15:0] raw,
                                           input logic [15:0] now);
        int          value, mag, delta, lane_dz, lane_sens;
        bit          report;
        logic [3:0]  level;
        qual_event_t ev;
        report = 1'b0;
        value  = 0;
        if (op == OP_AXIS && ch < NUM_AXES) begin
            lane_dz   = dz_reg[ch*16 +: 16];
            lane_sens = sens_reg[ch*16 +: 16];
            value = scale_axis(raw, ch);
            mag   = value < 0 ? -value : value;
            if (mag < lane_dz) begin
                value  = 0;
                report = 1'b1;
            end else if (value != last_axis[ch]) begin
                delta  = last_axis[ch] > value ? last_axis[ch] - value : value - last_axis[ch];
                report = delta >= lane_sens;
                last_axis[ch]  = value;
                hold_stamp[ch] = now;
            end else if (rep_en && value != 0) begin
                report = held_long(ch, now);
            end else begin
                hold_stamp[ch] = now;
            end
        end else if (op == OP_BUTTON && ch < NUM_BUTTONS) begin
            level  = (raw != 0) ? 4'd1 : 4'd0;
            report = level_report(NUM_AXES + ch, level, now);
            value  = level;
        end else if (op == OP_HAT && ch < NUM_HATS) begin
            level  = raw[3:0];
            report = level_report(NUM_AXES + NUM_BUTTONS + ch, level, now);
            value  = level;
        end else begin
            samples_ignored++;
        end
        if (report) begin
            ev.kind  = op;
            ev.ch    = ch;
            ev.value = 16'(value);
            expected_events.push_back(ev);
        end
    endfunction

    // --------------------------------------------------------- sample side

    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 80);
    endfunction

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sample_taken = 1'b1;
            samples_taken++;
            qualify_sample(s_opcode, s_channel, s_sample_value, s_time_now);
        end
    end

    always @(negedge aclk) begin : sample_driver
        sample_t nxt;
        if (aresetn && (!s_valid || sample_taken)) begin
            sample_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
                nxt = sample_queue.pop_front();
                s_opcode       <= nxt.op;
                s_channel      <= nxt.ch;
                s_sample_value <= nxt.raw;
                s_time_now     <= nxt.now;
                s_valid        <= 1'b1;
                gap_left = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------- event side

    always @(negedge aclk) begin : ready_gen
        int r;
        if (aresetn) begin
            if (hold_req && hold_left == 0) begin
                hold_left = LONG_HOLD;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (quiet) begin
                m_ready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 75) begin
                    m_ready <= 1'b1;
                end else if (r < 95) begin
                    stall_left = $urandom_range(0, 3);
                    m_ready <= 1'b0;
                end else begin
                    stall_left = $urandom_range(15, 70);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin : event_monitor
        qual_event_t want;
        if (aresetn && m_valid && m_ready) begin
            events_seen++;
            if (expected_events.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected event: kind=%0d ch=%0d value=%0d",
                             m_event_kind, m_event_channel, m_event_value);
            end else begin
                want = expected_events.pop_front();
                if (m_event_kind !== want.kind || m_event_channel !== want.ch ||
                    m_event_value !== want.value) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("event mismatch: expected kind=%0d ch=%0d value=%0d, got kind=%0d ch=%0d value=%0d",
                                 want.kind, want.ch, $signed(want.value),
                                 m_event_kind, m_event_channel, m_event_value);
                end
            end
        end
    end

    // ------------------------------------------------------------ sequencing

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_index   <= idx;
        cfg_wr_data <= data;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        case (idx)
            CFG_DEADZONES:     dz_reg    = data;
            CFG_SENSITIVITIES: sens_reg  = data;
            CFG_MINIMUMS:      min_reg   = data;
            CFG_MAXIMUMS:      max_reg   = data;
            CFG_REPEAT_EN:     rep_en    = data[0];
            CFG_REPEAT_DELAY:  rep_delay = data[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_setting(input logic [63:0] dz, input logic [63:0] sens,
                                 input logic [63:0] mins, input logic [63:0] maxs,
                                 input logic en, input logic [15:0] delay);
        write_reg(CFG_DEADZONES, dz);
        write_reg(CFG_SENSITIVITIES, sens);
        write_reg(CFG_MINIMUMS, mins);
        write_reg(CFG_MAXIMUMS, maxs);
        write_reg(CFG_REPEAT_EN, {63'd0, en});
        write_reg(CFG_REPEAT_DELAY, {48'd0, delay});
        settings_done++;
    endtask

    // sender holds off until every queued beat is taken and every event is back
    task automatic wait_idle();
        do @(posedge aclk);
        while (sample_queue.size() != 0 || s_valid || expected_events.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic push_sample(input logic [1:0] op, input logic [3:0] ch,
                               input logic signed [15:0] raw, input logic [15:0] now);
        sample_t s;
        s.op  = op;
        s.ch  = ch;
        s.raw = raw;
        s.now = now;
        sample_queue.push_back(s);
    endtask

    task automatic gen_samples(input int count);
        int                 made, r, ch;
        logic signed [15:0] raw;
        made = 0;
        while (made < count) begin
            r = $urandom_range(0, 99);
            if (r < 70)      tick = tick + 16'($urandom_range(0, 20));
            else if (r < 95) tick = tick + 16'($urandom_range(0, 300));
            else             tick = 16'($urandom);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                case ($urandom_range(0, 2))
                    0: push_sample(OP_NONE, 4'($urandom), 16'($urandom), tick);
                    1: push_sample(OP_AXIS, 4'($urandom_range(NUM_AXES, 15)),
                                   16'($urandom), tick);
                    default: push_sample(OP_HAT, 4'($urandom_range(NUM_HATS, 15)),
                                         16'($urandom), tick);
                endcase
                made++;
            end else if (r < 45) begin
                ch = $urandom_range(0, NUM_AXES - 1);
                r  = $urandom_range(0, 99);
                if (r < 40) raw = prev_axis_raw[ch];
                else if (r < 70) raw = 16'($urandom);
                else if (r < 85) raw = prev_axis_raw[ch] + 16'($signed($urandom_range(0, 600)) - 300);
                else begin
                    case ($urandom_range(0, 4))
                        0: raw = 16'sh8000;
                        1: raw = 16'sh7FFF;
                        2: raw = 16'sd0;
                        3: raw = 16'sd1;
                        default: raw = -16'sd1;
                    endcase
                end
                prev_axis_raw[ch] = raw;
                push_sample(OP_AXIS, 4'(ch), raw, tick);
                made++;
            end else if (r < 72) begin
                ch = $urandom_range(0, NUM_BUTTONS - 1);
                if ($urandom_range(0, 99) < 40) raw = prev_btn_raw[ch];
                else raw = $urandom_range(0, 1) ? 16'($urandom) : 16'sd0;
                prev_btn_raw[ch] = raw;
                push_sample(OP_BUTTON, 4'(ch), raw, tick);
                made++;
            end else begin
                ch = $urandom_range(0, NUM_HATS - 1);
                if ($urandom_range(0, 99) < 40) raw = prev_hat_raw[ch];
                else raw = 16'($urandom);
                prev_hat_raw[ch] = raw;
                push_sample(OP_HAT, 4'(ch), raw, tick);
                made++;
            end
        end
    endtask

    initial begin : main_seq
        logic [63:0] dz, sens, mins, maxs;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: full range calibration, axis 1 deadzone, axis 2 sensitivity
        quiet = 1'b1;
        apply_setting(64'h0000_0000_0064_0000, 64'h0000_03E8_0000_0000,
                      64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1, 16'd10);
        push_sample(OP_AXIS,   4'd0,  16'sh7FFF, 16'd0);
        push_sample(OP_AXIS,   4'd0,  16'sh8000, 16'd1);
        push_sample(OP_AXIS,   4'd0,  16'sh8000, 16'd5);
        push_sample(OP_AXIS,   4'd0,  16'sh8000, 16'd20);
        push_sample(OP_AXIS,   4'd1,  16'sd50,   16'd21);
        push_sample(OP_AXIS,   4'd1,  -16'sd100, 16'd22);
        push_sample(OP_AXIS,   4'd2,  16'sd500,  16'd23);
        push_sample(OP_AXIS,   4'd2,  16'sd2000, 16'd24);
        push_sample(OP_AXIS,   4'd3,  16'sd0,    16'd25);
        push_sample(OP_AXIS,   4'd4,  16'sd1234, 16'd26);
        push_sample(OP_AXIS,   4'd15, 16'sh7FFF, 16'd27);
        push_sample(OP_BUTTON, 4'd0,  16'sd1,    16'd28);
        push_sample(OP_BUTTON, 4'd15, 16'sh8000, 16'd29);
        push_sample(OP_BUTTON, 4'd15, 16'sh8000, 16'd60);
        push_sample(OP_BUTTON, 4'd0,  16'sd0,    16'd61);
        push_sample(OP_BUTTON, 4'd0,  16'sd0,    16'd62);
        push_sample(OP_HAT,    4'd0,  16'shFFFF, 16'd63);
        push_sample(OP_HAT,    4'd3,  16'shFFF0, 16'd64);
        push_sample(OP_HAT,    4'd4,  16'sd5,    16'd65);
        push_sample(OP_HAT,    4'd15, 16'sd5,    16'd66);
        push_sample(OP_NONE,   4'd0,  16'sd7,    16'd67);
        push_sample(OP_HAT,    4'd1,  16'sd5,    16'hFFFF);
        push_sample(OP_HAT,    4'd1,  16'sd5,    16'd4);
        push_sample(OP_HAT,    4'd1,  16'sd5,    16'd9);
        wait_idle();

        // full range, every change reported; receiver holds off early on
        quiet = 1'b0;
        apply_setting(64'd0, 64'd0, 64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF,
                      1'b0, 16'd500);
        hold_req = 1'b1;
        gen_samples(305);
        wait_idle();

        // random calibration, lane 3 inverted, short repeat delay
        for (int i = 0; i < NUM_AXES; i++) begin
            mins[i*16 +: 16] = 16'(-$signed($urandom_range(1, 20000)));
            maxs[i*16 +: 16] = 16'($urandom_range(0, 20000));
            dz[i*16 +: 16]   = 16'($urandom_range(0, 1500));
            sens[i*16 +: 16] = 16'($urandom_range(0, 400));
        end
        mins[63:48] = 16'sd300;
        maxs[63:48] = -16'sd300;
        apply_setting(dz, sens, mins, maxs, 1'b1, 16'($urandom_range(0, 60)));
        gen_samples(150);
        wait_idle();
        gen_samples(155);
        wait_idle();

        // extreme thresholds and longest delay
        apply_setting(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
                      64'h8000_8000_8000_8000, 64'h7FFF_7FFF_7FFF_7FFF, 1'b1, 16'hFFFF);
        gen_samples(305);
        wait_idle();

        // narrow calibration, saturating gain, zero delay, no idling
        quiet = 1'b1;
        for (int i = 0; i < NUM_AXES; i++) sens[i*16 +: 16] = 16'($urandom_range(0, 3));
        apply_setting(64'd0, sens, {16'sd100, 16'sd0, -16'sd1, -16'sd5},
                      {16'sd101, 16'sd1, 16'sd0, 16'sd5}, 1'b1, 16'd0);
        gen_samples(305);
        wait_idle();

        // fully random registers
        quiet = 1'b0;
        apply_setting({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, 1'($urandom), 16'($urandom));
        gen_samples(305);
        wait_idle();

        // inverted and equal bounds on lanes 0 and 1, repeat off
        apply_setting(64'd0, 64'd0, 64'hC000_8000_0000_7FFF, 64'h3FFF_7FFF_0000_8000,
                      1'b0, 16'd0);
        gen_samples(305);
        wait_idle();

        $display("%0d samples taken (%0d ignored) across %0d register settings",
                 samples_taken, samples_ignored, settings_done);
        $display("%0d events checked, %0d mismatches", events_seen, mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_NS);
        $display("timeout: %0d samples still queued, %0d events outstanding",
                 sample_queue.size(), expected_events.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
